// File: hdl/fba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fba_pkg;

    // frame geometry
    localparam int MAX_FRAMES = 65536;
    localparam int PAGE_BITS  = 12;
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int BOUND_W    = FRAME_W + 1;
    localparam int COUNT_W    = 17;

    // payload widths
    localparam int ADDR_W = 48;
    localparam int SPAN_W = ADDR_W + 1 - PAGE_BITS;

    // use map organization
    localparam int WORD_BITS  = 32;
    localparam int BIT_IDX_W  = $clog2(WORD_BITS);
    localparam int MAP_WORDS  = MAX_FRAMES / WORD_BITS;
    localparam int WORD_IDX_W = $clog2(MAP_WORDS);
    localparam int POP_W      = BIT_IDX_W + 1;
    localparam int LANE_W     = 8;
    localparam int LANES      = WORD_BITS / LANE_W;
    localparam int LANE_BIT_W = $clog2(LANE_W);
    localparam int LANE_IDX_W = $clog2(LANES);

    // request kinds
    localparam logic [1:0] KIND_ALLOC     = 2'd0;
    localparam logic [1:0] KIND_FREE      = 2'd1;
    localparam logic [1:0] KIND_MARK_FREE = 2'd2;
    localparam logic [1:0] KIND_MARK_USED = 2'd3;

    // result status codes
    localparam logic [1:0] ST_DONE         = 2'd0;
    localparam logic [1:0] ST_NO_FRAME     = 2'd1;
    localparam logic [1:0] ST_MISALIGNED   = 2'd2;
    localparam logic [1:0] ST_OUT_OF_RANGE = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] byte_address;
        logic [ADDR_W-1:0] byte_length;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [ADDR_W-1:0]  frame_address;
        logic [COUNT_W-1:0] free_count;
    } out_t;

    // one word of work for the shared word unit
    typedef struct packed {
        logic [WORD_IDX_W-1:0] widx;
        logic [BOUND_W-1:0]    lo;
        logic [BOUND_W-1:0]    hi;
        logic                  set_bits;
    } word_req_t;

    typedef struct packed {
        logic                 found;
        logic [BIT_IDX_W-1:0] pos;
        logic [WORD_BITS-1:0] alloc_word;
        logic [WORD_BITS-1:0] mark_word;
        logic [POP_W-1:0]     delta;
    } word_res_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SETUP,
        S_PLAN,
        S_READ,
        S_EVAL,
        S_FINISH,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

// File: hdl/fba_map_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fba_map_ram (
    input  wire logic                           aclk,
    input  wire logic                           wr_en,
    input  wire logic [fba_pkg::WORD_IDX_W-1:0] wr_addr,
    input  wire logic [fba_pkg::WORD_BITS-1:0]  wr_data,
    input  wire logic [fba_pkg::WORD_IDX_W-1:0] rd_addr,
    output logic      [fba_pkg::WORD_BITS-1:0]  rd_data
);
    import fba_pkg::*;

    logic [WORD_BITS-1:0] mem [MAP_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hdl/fba_word_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module fba_word_unit (
    input  wire fba_pkg::word_req_t              req,
    input  wire logic [fba_pkg::WORD_BITS-1:0]   rdata,
    output fba_pkg::word_res_t                   res
);
    import fba_pkg::*;

    localparam int HI_IDX_W = BOUND_W - BIT_IDX_W;

    logic [HI_IDX_W-1:0]   w_ext;
    logic [HI_IDX_W-1:0]   lo_word;
    logic [HI_IDX_W-1:0]   hi_word;
    logic [WORD_BITS-1:0]  ones;
    logic [WORD_BITS-1:0]  mask_lo;
    logic [WORD_BITS-1:0]  mask_hi;
    logic [WORD_BITS-1:0]  win;
    logic [WORD_BITS-1:0]  cand;
    logic [WORD_BITS-1:0]  changed;
    logic [LANES-1:0]      lane_any;
    logic [LANE_BIT_W-1:0] lane_pos [LANES];
    logic                  found;
    logic [BIT_IDX_W-1:0]  pos;
    logic [POP_W-1:0]      pop;

    assign ones    = '1;
    assign w_ext   = {1'b0, req.widx};
    assign lo_word = req.lo[BOUND_W-1:BIT_IDX_W];
    assign hi_word = req.hi[BOUND_W-1:BIT_IDX_W];

    // window of frames of this word that lie in [lo, hi)
    always_comb begin
        if (lo_word < w_ext) begin
            mask_lo = ones;
        end else if (lo_word == w_ext) begin
            mask_lo = ones << req.lo[BIT_IDX_W-1:0];
        end else begin
            mask_lo = '0;
        end
        if (hi_word > w_ext) begin
            mask_hi = ones;
        end else if (hi_word == w_ext) begin
            mask_hi = (WORD_BITS'(1) << req.hi[BIT_IDX_W-1:0]) - WORD_BITS'(1);
        end else begin
            mask_hi = '0;
        end
    end

    assign win     = mask_lo & mask_hi;
    assign cand    = win & ~rdata;
    assign changed = req.set_bits ? cand : (win & rdata);

    // lowest free frame: per-lane search, then lowest lane
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            lane_any[l] = |cand[l*LANE_W +: LANE_W];
            lane_pos[l] = '0;
            for (int b = LANE_W - 1; b >= 0; b--) begin
                if (cand[l*LANE_W + b]) begin
                    lane_pos[l] = LANE_BIT_W'(b);
                end
            end
        end
        found = |lane_any;
        pos   = '0;
        for (int l = LANES - 1; l >= 0; l--) begin
            if (lane_any[l]) begin
                pos = {LANE_IDX_W'(l), lane_pos[l]};
            end
        end
    end

    always_comb begin
        pop = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            pop = pop + POP_W'(changed[i]);
        end
    end

    assign res.found      = found;
    assign res.pos        = pos;
    assign res.alloc_word = rdata | (WORD_BITS'(1) << pos);
    assign res.mark_word  = req.set_bits ? (rdata | win) : (rdata & ~win);
    assign res.delta      = pop;

endmodule

`default_nettype wire

// File: hdl/frame_bitmap_allocator_core.sv
// steps from accept to m_valid: setup, plan, a map read and an evaluate per map word
//   visited (32 frames per word), a finish for frees and marks; rejected frees, empty
//   ranges, empty-map allocs skip to result; plus any wait for a prior result to drain
// throughput: one transaction at a time, s_ready returns in the cycle m_valid rises,
//   set by the single map port and word unit
// reset: synchronous, active low; map then filled with ones, all 2048 words, s_ready low
`timescale 1ns / 1ps
`default_nettype none

module frame_bitmap_allocator_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire fba_pkg::in_t                s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output fba_pkg::out_t                    m_data,
    input  wire logic                        cfg_wr_en,
    input  wire logic [fba_pkg::COUNT_W-1:0] cfg_wr_data
);
    import fba_pkg::*;

    // architectural state
    state_t                state_reg, state_next;
    logic [COUNT_W-1:0]    total_reg, total_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [FRAME_W-1:0]    cursor_reg, cursor_next;

    // per-transaction working registers
    in_t                   in_reg, in_next;
    logic [SPAN_W-1:0]     sf_reg, sf_next;
    logic [SPAN_W-1:0]     ef_reg, ef_next;
    logic                  misalign_reg, misalign_next;
    logic [BOUND_W-1:0]    lo_reg, lo_next;
    logic [BOUND_W-1:0]    hi_reg, hi_next;
    logic [WORD_IDX_W-1:0] w_reg, w_next;
    logic                  phase2_reg, phase2_next;
    logic                  set_reg, set_next;
    logic [POP_W-1:0]      delta_reg, delta_next;
    logic [1:0]            status_reg, status_next;
    logic [ADDR_W-1:0]     faddr_reg, faddr_next;

    // result register
    logic                  m_valid_reg, m_valid_next;
    out_t                  m_data_reg, m_data_next;

    // map port and word unit
    logic                  ram_we;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [WORD_BITS-1:0]  ram_rdata;
    word_req_t             wreq;
    word_res_t             wres;

    // derived bounds
    logic [BOUND_W-1:0]    tot;
    logic [BOUND_W-1:0]    lim;
    logic [SPAN_W-1:0]     tot_span;
    logic [SPAN_W-1:0]     ef_clip;
    logic [ADDR_W:0]       sum_start;
    logic [ADDR_W:0]       sum_end;
    logic [SPAN_W-1:0]     free_idx;
    logic [BOUND_W-BIT_IDX_W-1:0] w_inc;
    logic                  range_end;

    fba_map_ram u_map (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (w_reg),
        .wr_data (ram_wdata),
        .rd_addr (w_reg),
        .rd_data (ram_rdata)
    );

    assign wreq.widx     = w_reg;
    assign wreq.lo       = lo_reg;
    assign wreq.hi       = hi_reg;
    assign wreq.set_bits = set_reg;

    fba_word_unit u_word (
        .req   (wreq),
        .rdata (ram_rdata),
        .res   (wres)
    );

    // effective total saturates at the map size
    assign tot = (total_reg > BOUND_W'(MAX_FRAMES)) ? BOUND_W'(MAX_FRAMES) : total_reg;
    // wrapped search stops below both cursor and total
    assign lim = ({1'b0, cursor_reg} < tot) ? {1'b0, cursor_reg} : tot;
    assign tot_span = {{(SPAN_W-BOUND_W){1'b0}}, tot};
    assign ef_clip  = (ef_reg > tot_span) ? tot_span : ef_reg;

    // whole frames of the range: round start up, end down
    assign sum_start = {1'b0, in_reg.byte_address} + (ADDR_W+1)'((1 << PAGE_BITS) - 1);
    assign sum_end   = {1'b0, in_reg.byte_address} + {1'b0, in_reg.byte_length};
    assign free_idx  = {1'b0, in_reg.byte_address[ADDR_W-1:PAGE_BITS]};

    // last word of the window once the next word starts at or past hi
    assign w_inc     = {1'b0, w_reg} + (BOUND_W-BIT_IDX_W)'(1);
    assign range_end = {w_inc, {BIT_IDX_W{1'b0}}} >= hi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            total_reg   <= '0;
            count_reg   <= '0;
            cursor_reg  <= '0;
            w_reg       <= '0;
            delta_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            count_reg   <= count_next;
            cursor_reg  <= cursor_next;
            w_reg       <= w_next;
            delta_reg   <= delta_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        in_reg       <= in_next;
        sf_reg       <= sf_next;
        ef_reg       <= ef_next;
        misalign_reg <= misalign_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        phase2_reg   <= phase2_next;
        set_reg      <= set_next;
        status_reg   <= status_next;
        faddr_reg    <= faddr_next;
        m_data_reg   <= m_data_next;
    end

    always_comb begin
        state_next    = state_reg;
        total_next    = total_reg;
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        in_next       = in_reg;
        sf_next       = sf_reg;
        ef_next       = ef_reg;
        misalign_next = misalign_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        w_next        = w_reg;
        phase2_next   = phase2_reg;
        set_next      = set_reg;
        delta_next    = delta_reg;
        status_next   = status_reg;
        faddr_next    = faddr_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        s_ready       = 1'b0;
        ram_we        = 1'b0;
        ram_wdata     = wres.mark_word;

        // config register, to be written only while idle; the block itself does not enforce this
        if (cfg_wr_en) begin
            total_next = cfg_wr_data;
        end

        // result taken downstream
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            // fill the map with ones after reset
            S_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = '1;
                w_next    = w_reg + WORD_IDX_W'(1);
                if (w_reg == '1) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    in_next     = s_data;
                    status_next = ST_DONE;
                    faddr_next  = '0;
                    phase2_next = 1'b0;
                    state_next  = S_SETUP;
                end
            end

            // frame bounds of the transaction
            S_SETUP: begin
                misalign_next = |in_reg.byte_address[PAGE_BITS-1:0];
                if (in_reg.kind == KIND_FREE) begin
                    sf_next = free_idx;
                    ef_next = free_idx + SPAN_W'(1);
                end else begin
                    sf_next = sum_start[ADDR_W:PAGE_BITS];
                    ef_next = sum_end[ADDR_W:PAGE_BITS];
                end
                set_next   = (in_reg.kind == KIND_MARK_USED);
                state_next = S_PLAN;
            end

            // pick the first search window or reject
            S_PLAN: begin
                if (in_reg.kind == KIND_ALLOC) begin
                    set_next = 1'b1;
                    if ({1'b0, cursor_reg} < tot) begin
                        lo_next    = {1'b0, cursor_reg};
                        hi_next    = tot;
                        w_next     = cursor_reg[FRAME_W-1:BIT_IDX_W];
                        state_next = S_READ;
                    end else if (lim != '0) begin
                        phase2_next = 1'b1;
                        lo_next     = '0;
                        hi_next     = lim;
                        w_next      = '0;
                        state_next  = S_READ;
                    end else begin
                        status_next = ST_NO_FRAME;
                        state_next  = S_RESP;
                    end
                end else if ((in_reg.kind == KIND_FREE) && misalign_reg) begin
                    status_next = ST_MISALIGNED;
                    state_next  = S_RESP;
                end else if ((in_reg.kind == KIND_FREE) && (sf_reg >= tot_span)) begin
                    status_next = ST_OUT_OF_RANGE;
                    state_next  = S_RESP;
                end else if (sf_reg >= ef_clip) begin
                    // empty or fully clipped range
                    state_next = S_RESP;
                end else begin
                    lo_next    = sf_reg[BOUND_W-1:0];
                    hi_next    = ef_clip[BOUND_W-1:0];
                    w_next     = sf_reg[FRAME_W-1:BIT_IDX_W];
                    state_next = S_READ;
                end
            end

            // map read in flight; fold in the previous word's count change
            S_READ: begin
                count_next = set_reg ? (count_reg - COUNT_W'(delta_reg))
                                     : (count_reg + COUNT_W'(delta_reg));
                delta_next = '0;
                state_next = S_EVAL;
            end

            S_EVAL: begin
                if (in_reg.kind == KIND_ALLOC) begin
                    if (wres.found) begin
                        ram_we      = 1'b1;
                        ram_wdata   = wres.alloc_word;
                        count_next  = count_reg - COUNT_W'(1);
                        cursor_next = {w_reg, wres.pos};
                        faddr_next  = {{(ADDR_W-FRAME_W-PAGE_BITS){1'b0}},
                                       w_reg, wres.pos, {PAGE_BITS{1'b0}}};
                        status_next = ST_DONE;
                        state_next  = S_RESP;
                    end else if (!range_end) begin
                        w_next     = w_reg + WORD_IDX_W'(1);
                        state_next = S_READ;
                    end else if (!phase2_reg && (lim != '0)) begin
                        // wrap to frame 0
                        phase2_next = 1'b1;
                        lo_next     = '0;
                        hi_next     = lim;
                        w_next      = '0;
                        state_next  = S_READ;
                    end else begin
                        status_next = ST_NO_FRAME;
                        state_next  = S_RESP;
                    end
                end else begin
                    ram_we     = 1'b1;
                    ram_wdata  = wres.mark_word;
                    delta_next = wres.delta;
                    if (range_end) begin
                        state_next = S_FINISH;
                    end else begin
                        w_next     = w_reg + WORD_IDX_W'(1);
                        state_next = S_READ;
                    end
                end
            end

            S_FINISH: begin
                count_next = set_reg ? (count_reg - COUNT_W'(delta_reg))
                                     : (count_reg + COUNT_W'(delta_reg));
                delta_next = '0;
                state_next = S_RESP;
            end

            // hand the result to the output register when it is free
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.status        = status_reg;
                    m_data_next.frame_address = faddr_reg;
                    m_data_next.free_count    = count_reg;
                    m_valid_next              = 1'b1;
                    state_next                = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// File: hdl/fba_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module fba_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_valid,
    input wire logic          s_ready,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire fba_pkg::out_t m_data
);
    import fba_pkg::*;

    // a waiting result holds until taken
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one transaction in work at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // only a successful alloc returns an address
    a_addr_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ST_DONE) |-> (m_data.frame_address == '0))
        else $error("address on failed transaction");

    a_addr_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.frame_address[PAGE_BITS-1:0] == '0))
        else $error("unaligned frame address");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.free_count <= COUNT_W'(MAX_FRAMES)))
        else $error("free count above map size");

endmodule

bind frame_bitmap_allocator_core fba_checker u_fba_checker (.*);

`default_nettype wire

// File: tb/frame_bitmap_allocator_checker.sv
`timescale 1ns / 1ps

module frame_bitmap_allocator_checker (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    input  wire logic                        s_ready,
    input  wire fba_pkg::in_t                s_data,
    input  wire logic                        m_valid,
    input  wire logic                        m_ready,
    input  wire fba_pkg::out_t               m_data,
    input  wire logic                        cfg_wr_en,
    input  wire logic [fba_pkg::COUNT_W-1:0] cfg_wr_data,
    output int                               fail_count,
    output int                               pending
);
    import fba_pkg::*;

    bit                 frame_used [MAX_FRAMES];
    int unsigned        free_total;
    int unsigned        cursor;
    logic [COUNT_W-1:0] total_reg;
    out_t               result_q [$];
    out_t               want;
    int                 errors = 0;

    function automatic int unsigned managed_frames();
        return (total_reg > MAX_FRAMES) ? MAX_FRAMES : int'(total_reg);
    endfunction

    // first free frame in [lo, hi), or -1
    function automatic int find_free(int unsigned lo, int unsigned hi);
        for (int unsigned f = lo; f < hi; f++) begin
            if (!frame_used[f]) return int'(f);
        end
        return -1;
    endfunction

    function automatic out_t allocator_step(in_t item);
        out_t              r;
        int unsigned       tot;
        int unsigned       lim;
        int                hit;
        longint unsigned   a;
        longint unsigned   first;
        longint unsigned   last;
        bit                target;
        r        = '0;
        r.status = ST_DONE;
        tot      = managed_frames();
        a        = longint'(item.byte_address);
        case (item.kind)
            KIND_ALLOC: begin
                lim = (cursor < tot) ? cursor : tot;
                hit = find_free(cursor, tot);
                if (hit < 0) hit = find_free(0, lim);
                if (hit < 0) begin
                    r.status = ST_NO_FRAME;
                end else begin
                    frame_used[hit] = 1'b1;
                    free_total--;
                    cursor = hit;
                    r.frame_address = ADDR_W'(longint'(hit) << PAGE_BITS);
                end
            end
            KIND_FREE: begin
                if (item.byte_address[PAGE_BITS-1:0] != '0) begin
                    r.status = ST_MISALIGNED;
                end else if ((a >> PAGE_BITS) >= tot) begin
                    r.status = ST_OUT_OF_RANGE;
                end else if (frame_used[a >> PAGE_BITS]) begin
                    frame_used[a >> PAGE_BITS] = 1'b0;
                    free_total++;
                end
            end
            default: begin
                // whole frames inside the range, clipped to the total
                target = (item.kind == KIND_MARK_USED);
                first  = (a + (64'd1 << PAGE_BITS) - 1) >> PAGE_BITS;
                last   = (a + longint'(item.byte_length)) >> PAGE_BITS;
                if (last > tot) last = tot;
                for (longint unsigned f = first; f < last; f++) begin
                    if (frame_used[f] != target) begin
                        frame_used[f] = target;
                        if (target) free_total--;
                        else free_total++;
                    end
                end
            end
        endcase
        r.free_count = COUNT_W'(free_total);
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (frame_used[i]) frame_used[i] = 1'b1;
            free_total = 0;
            cursor     = 0;
            total_reg  = '0;
            result_q.delete();
        end else begin
            if (cfg_wr_en) total_reg = cfg_wr_data;
            if (s_valid && s_ready) result_q.push_back(allocator_step(s_data));
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual status=%0d addr=%h free=%0d",
                             $time, m_data.status, m_data.frame_address,
                             m_data.free_count);
                end else begin
                    want = result_q.pop_front();
                    if (m_data.status !== want.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_data.status);
                    end
                    if (m_data.frame_address !== want.frame_address) begin
                        errors++;
                        $display("%0t: frame_address expected %h actual %h",
                                 $time, want.frame_address, m_data.frame_address);
                    end
                    if (m_data.free_count !== want.free_count) begin
                        errors++;
                        $display("%0t: free_count expected %0d actual %0d",
                                 $time, want.free_count, m_data.free_count);
                    end
                end
            end
        end
        pending    <= result_q.size();
        fail_count <= errors;
    end

endmodule

// File: tb/frame_bitmap_allocator_core_tb.sv
`timescale 1ns / 1ps

module frame_bitmap_allocator_core_tb;
    import fba_pkg::*;

    // random phase sizes: small totals get many transactions, huge ones only a few
    localparam int PHASE_ITEMS      = 145;
    localparam int LARGE_ITEMS      = 12;
    localparam int SMALL_TOTAL_MAX  = 1024;
    // long receiver hold-off so the block fills and stalls its input
    localparam int SINK_HOLD_CYCLES = 600;
    // quiet cycles after the last result before a config write or the verdict
    localparam int SETTLE_CYCLES    = 16;
    // full map scans read all 2048 map words; this leaves a wide margin
    localparam longint TIMEOUT_NS   = 64'd12_000_000;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    in_t                s_data      = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    out_t               m_data;
    logic               cfg_wr_en   = 1'b0;
    logic [COUNT_W-1:0] cfg_wr_data = '0;

    int fail_count;
    int pending;

    // burst modes: while set, that side never idles
    bit src_calm  = 1'b0;
    bit sink_calm = 1'b0;
    // one-shot request for the receiver to hold off
    bit sink_hold = 1'b0;

    // totals per random phase, covering empty, tiny, odd, full and oversized maps
    int unsigned phase_totals [16] = '{256, 64, 1, 33, 512, 0, 97, 2,
                                       320, 65536, 128, 131071, 480, 100000, 48, 64};

    always #2 aclk = ~aclk;

    frame_bitmap_allocator_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    frame_bitmap_allocator_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // hard stop in case the handshake hangs
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] rand_addr48();
        return {16'($urandom()), 32'($urandom())};
    endfunction

    function automatic logic [ADDR_W-1:0] page_addr(int unsigned frame);
        return ADDR_W'(frame) << PAGE_BITS;
    endfunction

    // idle cycles before the next transaction, occasionally flipping burst mode
    function automatic int unsigned draw_gap(inout bit calm);
        if ($urandom_range(0, 47) == 0) calm = ($urandom_range(0, 3) == 0);
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    // mostly well-formed requests aimed at the managed frames, some noise
    function automatic in_t random_request(int unsigned tot);
        in_t         req;
        int unsigned span;
        int unsigned pick;
        span             = (tot == 0) ? 1 : tot;
        pick             = $urandom_range(0, 99);
        // ignored fields still carry random junk
        req.kind         = KIND_ALLOC;
        req.byte_address = rand_addr48();
        req.byte_length  = rand_addr48();
        if (pick < 35) begin
            req.kind = KIND_ALLOC;
        end else if (pick < 65) begin
            req.kind = KIND_FREE;
            // a few land just past the total
            req.byte_address = page_addr($urandom_range(0, span + span / 8));
            if ($urandom_range(0, 9) == 0)
                req.byte_address[PAGE_BITS-1:0] = PAGE_BITS'($urandom_range(1, 4095));
        end else if (pick < 95) begin
            req.kind = (pick < 80) ? KIND_MARK_FREE : KIND_MARK_USED;
            req.byte_address = page_addr($urandom_range(0, span));
            req.byte_length  = page_addr($urandom_range(0, 40));
            // partial pages at either end
            if ($urandom_range(0, 2) == 0)
                req.byte_address = req.byte_address + ADDR_W'($urandom_range(1, 4095));
            if ($urandom_range(0, 2) == 0)
                req.byte_length = req.byte_length + ADDR_W'($urandom_range(1, 4095));
        end else begin
            // raw noise on every field
            req.kind = 2'($urandom_range(0, 3));
        end
        return req;
    endfunction

    // offer one transaction and hold it until accepted
    task automatic issue(logic [1:0] kind, logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] len);
        int unsigned gap;
        gap = draw_gap(src_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{kind: kind, byte_address: addr, byte_length: len};
        do @(posedge aclk); while (!s_ready);
    endtask

    // sender pauses until every expected result has come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_total(logic [COUNT_W-1:0] value);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // result side: random stalls, burst stretches and one long hold-off
    initial begin : result_sink
        int unsigned stall;
        forever begin
            if (sink_hold) begin
                stall     = SINK_HOLD_CYCLES;
                sink_hold = 1'b0;
            end else begin
                stall = draw_gap(sink_calm);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin : stimulus
        in_t         req;
        int unsigned tot;
        int unsigned count;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // empty total: nothing to allocate, every free out of range
        write_total(COUNT_W'(0));
        issue(KIND_ALLOC, '0, '0);
        issue(KIND_FREE, '0, '0);
        wait_idle();

        write_total(COUNT_W'(64));
        // map still all in use after reset
        issue(KIND_ALLOC, '0, '0);
        issue(KIND_FREE, 48'h1001, '0);
        issue(KIND_FREE, page_addr(64), '0);
        // release the whole map, then again with nothing left to change
        issue(KIND_MARK_FREE, '0, page_addr(64));
        issue(KIND_MARK_FREE, '0, page_addr(64));
        // free of an already free frame keeps the count
        issue(KIND_FREE, page_addr(5), '0);
        issue(KIND_ALLOC, '0, '0);
        issue(KIND_ALLOC, '0, '0);
        // unaligned range covers only frames 1 and 2, frame 1 already used
        issue(KIND_MARK_USED, 48'h800, page_addr(3));
        // empty range
        issue(KIND_MARK_FREE, page_addr(8), '0);
        // field extremes: range starts far past the map, free out of range, misaligned
        issue(KIND_MARK_USED, '1, '1);
        issue(KIND_FREE, {{(ADDR_W-PAGE_BITS){1'b1}}, {PAGE_BITS{1'b0}}}, '1);
        issue(KIND_FREE, 48'hFFF, '0);
        // fill the map and try again
        issue(KIND_MARK_USED, '0, page_addr(64));
        issue(KIND_ALLOC, '0, '0);
        // cursor moves up to frame 63
        issue(KIND_FREE, page_addr(63), '0);
        issue(KIND_ALLOC, '0, '0);
        issue(KIND_FREE, page_addr(40), '0);
        issue(KIND_FREE, page_addr(10), '0);
        wait_idle();

        // shrink below the cursor: only the wrapped part is searched, frame 40
        // stays free beyond the total and keeps its share of the count
        write_total(COUNT_W'(32));
        issue(KIND_ALLOC, '0, '0);
        issue(KIND_ALLOC, '0, '0);
        wait_idle();

        // oversized total saturates to the full map
        write_total('1);
        issue(KIND_FREE, page_addr(MAX_FRAMES - 1), '0);
        issue(KIND_ALLOC, '0, '0);
        issue(KIND_ALLOC, '0, '0);

        // random phases, each with its own total
        foreach (phase_totals[p]) begin
            wait_idle();
            write_total(COUNT_W'(phase_totals[p]));
            tot   = (phase_totals[p] > MAX_FRAMES) ? MAX_FRAMES : phase_totals[p];
            count = (tot > SMALL_TOTAL_MAX) ? LARGE_ITEMS : PHASE_ITEMS;
            // back-pressure while the sender keeps offering
            if (p == 1) sink_hold = 1'b1;
            repeat (count) begin
                req = random_request(tot);
                issue(req.kind, req.byte_address, req.byte_length);
            end
        end

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: frame_bitmap_allocator_core.f
hdl/fba_pkg.sv
hdl/fba_map_ram.sv
hdl/fba_word_unit.sv
hdl/frame_bitmap_allocator_core.sv
hdl/fba_checker.sv
tb/frame_bitmap_allocator_checker.sv
tb/frame_bitmap_allocator_core_tb.sv
